### rtl/bounded_shortest_job_queue_defines.svh
// ----------------------------------------------------------------------------
// Bounded shortest-job queue: assertion macros
// Shared assertion forms. The using scope provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SHORTEST_JOB_QUEUE_DEFINES_SVH
`define BOUNDED_SHORTEST_JOB_QUEUE_DEFINES_SVH

// Holds at every clock edge outside reset.
`define BSJQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The antecedent in one cycle implies the consequent in the next cycle.
`define BSJQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bsjq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded shortest-job queue package
// Sizes, codes and the types shared by the queue cells and the top level.
// ----------------------------------------------------------------------------
package bsjq_pkg;

	// Queue storage.
	localparam int DEPTH = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Field widths.
	localparam int ID_W  = 32;
	localparam int LEN_W = 48;
	localparam int OCC_W = 7;
	localparam int CAP_W = 7;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b1;

	// Reset values of the registers.
	localparam logic             POLICY_RESET   = 1'b1;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

	// Operation codes.
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	// Result codes.
	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_REJECTED = 2'd1,
		ST_DEQUEUED = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// A job that walks down the chain toward its slot.
	typedef struct packed {
		logic             valid;
		logic             shift;
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] len;
	} tok_t;

	// Per-cell control from the top level.
	typedef struct packed {
		logic deq;
		logic sjn;
		logic tail;
	} cell_ctrl_t;

endpackage

### rtl/bsjq_job_if.sv
// ----------------------------------------------------------------------------
// Job request channel
// Valid/ready channel that carries one queue operation per transaction.
// ----------------------------------------------------------------------------
interface bsjq_job_if;
	import bsjq_pkg::*;

	logic             valid;
	logic             ready;
	logic             opcode;
	logic [ID_W-1:0]  job_id;
	logic [LEN_W-1:0] job_length;

	modport source (output valid, opcode, job_id, job_length, input ready);
	modport sink (input valid, opcode, job_id, job_length, output ready);
endinterface

### rtl/bsjq_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result per transaction.
// ----------------------------------------------------------------------------
interface bsjq_result_if;
	import bsjq_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [ID_W-1:0]  out_job_id;
	logic [LEN_W-1:0] out_job_length;
	logic [OCC_W-1:0] occupancy;

	modport source (output valid, status, out_job_id, out_job_length, occupancy,
		input ready);
	modport sink (input valid, status, out_job_id, out_job_length, occupancy,
		output ready);
endinterface

### rtl/bsjq_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that writes one register per transaction.
// ----------------------------------------------------------------------------
interface bsjq_cfg_if;
	import bsjq_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/bounded_shortest_job_queue.sv
// ----------------------------------------------------------------------------
// Bounded shortest-job queue
// Job queue of up to DEPTH entries held in a chain of cells, head in cell 0.
// Orders jobs by arrival or by length, rejects when full, pops the head.
// ----------------------------------------------------------------------------
//  Channel      Direction  Transaction
//  job_in       in         one enqueue or dequeue request
//  result_out   out        one result per request
//  cfg          in         one register write (policy, capacity)
//
// A dequeue or a rejected enqueue starts no walk. An accepted enqueue walks down
// the cell chain one cell per cycle, and job_in stays busy until the walk, as long
// in cells as the occupancy after the insert, is done. The result is registered and
// the next request is taken in the cycle it leaves. Reset clears the count and sets
// the registers to their reset values; slot contents are not cleared. Configuration
// waits for the walk to finish and wins over a request offered in the same cycle.
module bounded_shortest_job_queue (
	input  logic  clk,
	input  logic  arst_n,
	bsjq_job_if.sink      job_in,
	bsjq_result_if.source result_out,
	bsjq_cfg_if.sink      cfg
);
	import bsjq_pkg::*;
	`include "bounded_shortest_job_queue_defines.svh"

	logic             policy_q;
	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] wait_q;
	logic [CNT_W-1:0] cnt_next;
	logic             inj_valid_q;
	logic [ID_W-1:0]  inj_id_q;
	logic [LEN_W-1:0] inj_len_q;

	logic             out_valid_q;
	status_t          status_q;
	logic [ID_W-1:0]  out_id_q;
	logic [LEN_W-1:0] out_len_q;
	logic [OCC_W-1:0] occ_q;

	logic             in_acc;
	logic             is_enq;
	logic             full;
	logic             enq_ok;
	logic             deq_go;
	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] cnt_next_ext;

	tok_t             tok [DEPTH+1];
	logic [ID_W-1:0]  id_a [DEPTH+1];
	logic [LEN_W-1:0] len_a [DEPTH+1];
	cell_ctrl_t       ctrl [DEPTH];

	// Request handshake and decode.
	assign job_in.ready = (wait_q == '0) && !cfg.valid && (!out_valid_q || result_out.ready);
	assign in_acc       = job_in.valid && job_in.ready;
	assign is_enq       = (job_in.opcode == OP_ENQUEUE);
	assign cnt_ext      = CMP_W'(cnt_q);
	assign full         = (cnt_ext >= CMP_W'(cap_q)) || (cnt_ext >= CMP_W'(DEPTH));
	assign enq_ok       = in_acc && is_enq && !full;
	assign deq_go       = in_acc && !is_enq && (cnt_q != '0);

	// Count after this request.
	always_comb begin
		cnt_next = cnt_q;
		if (enq_ok) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (deq_go) begin
			cnt_next = cnt_q - CNT_W'(1);
		end
	end
	assign cnt_next_ext = CMP_W'(cnt_next);

	// Configuration writes, held off while an inserted job walks the chain.
	assign cfg.ready = (wait_q == '0);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_RESET;
			cap_q    <= CAPACITY_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_POLICY:   policy_q <= cfg.data[0];
				REG_CAPACITY: cap_q    <= cfg.data[CAP_W-1:0];
				default:      ;
			endcase
		end
	end

	// Count, insert wait and result control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			wait_q      <= '0;
			inj_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q       <= cnt_next;
			inj_valid_q <= enq_ok;
			if (enq_ok) begin
				wait_q <= cnt_next;
			end else if (wait_q != '0) begin
				wait_q <= wait_q - CNT_W'(1);
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Injected job and result payload.
	always_ff @(posedge clk) begin
		inj_id_q  <= job_in.job_id;
		inj_len_q <= job_in.job_length;
		if (in_acc) begin
			occ_q     <= cnt_next_ext[OCC_W-1:0];
			out_id_q  <= '0;
			out_len_q <= '0;
			if (is_enq) begin
				if (full) begin
					status_q <= ST_REJECTED;
					out_id_q <= job_in.job_id;
				end else begin
					status_q <= ST_ACCEPTED;
				end
			end else if (cnt_q == '0) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q  <= ST_DEQUEUED;
				out_id_q  <= id_a[0];
				out_len_q <= len_a[0];
			end
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.status         = status_q;
	assign result_out.out_job_id     = out_id_q;
	assign result_out.out_job_length = out_len_q;
	assign result_out.occupancy      = occ_q;

	// Cell chain. Past the last cell the shifted-in slot is empty.
	assign tok[0]       = '{valid: inj_valid_q, shift: 1'b0, id: inj_id_q, len: inj_len_q};
	assign id_a[DEPTH]  = '0;
	assign len_a[DEPTH] = '0;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		assign ctrl[k] = '{deq: deq_go, sjn: policy_q, tail: (cnt_q == CNT_W'(k + 1))};

		bsjq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[k]),
			.tok_in    (tok[k]),
			.right_id  (id_a[k+1]),
			.right_len (len_a[k+1]),
			.tok_out   (tok[k+1]),
			.id_q      (id_a[k]),
			.len_q     (len_a[k])
		);
	end

	// Checks on the chain and the count.
	`BSJQ_ASSERT(a_no_overrun, !tok[DEPTH].valid, "job walked past the last cell")
	`BSJQ_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "count above depth")
	`BSJQ_ASSERT(a_inj_busy, !inj_valid_q || (wait_q != '0), "injected job without wait")
	`BSJQ_ASSERT_NEXT(a_enq_count, enq_ok, cnt_q == $past(cnt_q) + CNT_W'(1), "enqueue count slip")
	`BSJQ_ASSERT_NEXT(a_result_up, in_acc, out_valid_q, "result not raised")
endmodule

### rtl/bsjq_cell.sv
// ----------------------------------------------------------------------------
// Queue cell
// Holds one job slot. Takes the job walking in from the left when it belongs
// here, hands the displaced or passing job to the right, and shifts left on a
// dequeue.
// ----------------------------------------------------------------------------
module bsjq_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bsjq_pkg::cell_ctrl_t           ctrl,
	input  bsjq_pkg::tok_t                 tok_in,
	input  logic [bsjq_pkg::ID_W-1:0]      right_id,
	input  logic [bsjq_pkg::LEN_W-1:0]     right_len,
	output bsjq_pkg::tok_t                 tok_out,
	output logic [bsjq_pkg::ID_W-1:0]      id_q,
	output logic [bsjq_pkg::LEN_W-1:0]     len_q
);
	import bsjq_pkg::*;

	logic             take;
	tok_t             tok_next;
	logic             tok_valid_q;
	logic             tok_shift_q;
	logic [ID_W-1:0]  tok_id_q;
	logic [LEN_W-1:0] tok_len_q;

	// The job settles here at the tail, after an earlier displacement, or in
	// front of a strictly longer job when ordering by length.
	assign take = tok_in.valid
		&& (ctrl.tail || tok_in.shift || (ctrl.sjn && (tok_in.len < len_q)));

	// A displaced job travels on and forces every later cell to shift.
	always_comb begin
		if (take) begin
			tok_next = '{valid: 1'b1, shift: 1'b1, id: id_q, len: len_q};
		end else begin
			tok_next = tok_in;
		end
		tok_next.valid = tok_in.valid && !ctrl.tail;
	end

	// Slot contents.
	always_ff @(posedge clk) begin
		if (ctrl.deq) begin
			id_q  <= right_id;
			len_q <= right_len;
		end else if (take) begin
			id_q  <= tok_in.id;
			len_q <= tok_in.len;
		end
	end

	// Valid flag of the outgoing job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_next.valid;
		end
	end

	// Payload of the outgoing job.
	always_ff @(posedge clk) begin
		tok_shift_q <= tok_next.shift;
		tok_id_q    <= tok_next.id;
		tok_len_q   <= tok_next.len;
	end

	assign tok_out = '{valid: tok_valid_q, shift: tok_shift_q, id: tok_id_q, len: tok_len_q};
endmodule

### verif/bounded_shortest_job_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded shortest-job queue testbench
// Drives enqueue and dequeue requests through the job channel under several
// policy and capacity settings, with random gaps on both sides. Every result
// is checked against a scoreboard that keeps its own sorted job list.
// ----------------------------------------------------------------------------
module bounded_shortest_job_queue_test;
	import bsjq_pkg::*;

	localparam int     CLK_HALF_NS        = 4;
	localparam int     RESET_CYCLES       = 9;
	localparam int     SETTLE_CYCLES      = DEPTH + 8;
	localparam int     LONG_HOLD_CYCLES   = 300;
	localparam longint LIMIT_NS           = 64'd12_000_000;
	localparam int     PHASES             = 12;
	localparam int     FIRST_RANDOM_PHASE = 8;
	localparam int     LAST_RANDOM_PHASE  = 10;
	localparam int     PAUSE_PHASE        = 5;
	localparam int     DIRECTED_ROWS      = 22;

	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_SJN  = 1'b1;

	localparam logic [ID_W-1:0]  ID_MAX  = '1;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	typedef struct packed {
		status_t          status;
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] len;
		logic [OCC_W-1:0] occ;
	} job_result_t;

	// One row of the directed sequence: a register write or a request.
	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic                  op;
		logic [ID_W-1:0]       id;
		logic [LEN_W-1:0]      len;
		logic                  typed;
		job_result_t           want;
	} queue_step_t;

	localparam job_result_t NO_CHECK = '0;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bsjq_job_if    job_ch ();
	bsjq_result_if res_ch ();
	bsjq_cfg_if    cfg_ch ();

	bounded_shortest_job_queue dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_in     (job_ch),
		.result_out (res_ch),
		.cfg        (cfg_ch)
	);

	// Directed sequence: extremes, ties, policy change with jobs held,
	// capacity lowered below the count, zero capacity and saturation.
	queue_step_t directed_steps [DIRECTED_ROWS] = '{
		'{1'b0, REG_POLICY, 7'd0, OP_DEQUEUE, 32'h0, 48'h0, 1'b1,
			'{ST_EMPTY, 32'h0, 48'h0, 7'd0}},
		'{1'b0, REG_POLICY, 7'd0, OP_ENQUEUE, ID_MAX, LEN_MAX, 1'b1,
			'{ST_ACCEPTED, 32'h0, 48'h0, 7'd1}},
		'{1'b0, REG_POLICY, 7'd0, OP_ENQUEUE, 32'h0, 48'h0, 1'b0, NO_CHECK},
		'{1'b0, REG_POLICY, 7'd0, OP_ENQUEUE, 32'hA5A5_A5A5, 48'd5, 1'b0, NO_CHECK},
		'{1'b0, REG_POLICY, 7'd0, OP_ENQUEUE, 32'h5A5A_5A5A, 48'd5, 1'b0, NO_CHECK},
		'{1'b1, REG_POLICY, {6'd0, POLICY_FIFO}, OP_ENQUEUE, 32'h0, 48'h0, 1'b0, NO_CHECK},
		'{1'b0, REG_POLICY, 7'd0, OP_ENQUEUE, 32'd7, 48'd1, 1'b0, NO_CHECK},
		'{1'b1, REG_POLICY, {6'd0, POLICY_SJN}, OP_ENQUEUE, 32'h0, 48'h0, 1'b0, NO_CHECK},
		'{1'b0, REG_POLICY, 7'd0, OP_ENQUEUE, 32'd8, 48'd3, 1'b0, NO_CHECK},
		'{1'b1, REG_CAPACITY, 7'd2, OP_ENQUEUE, 32'h0, 48'h0, 1'b0, NO_CHECK},
		'{1'b0, REG_POLICY, 7'd0, OP_ENQUEUE, 32'd9, 48'd2, 1'b1,
			'{ST_REJECTED, 32'd9, 48'h0, 7'd6}},
		'{1'b0, REG_POLICY, 7'd0, OP_DEQUEUE, 32'h0, 48'h0, 1'b0, NO_CHECK},
		'{1'b1, REG_CAPACITY, 7'd0, OP_ENQUEUE, 32'h0, 48'h0, 1'b0, NO_CHECK},
		'{1'b0, REG_POLICY, 7'd0, OP_ENQUEUE, 32'd10, 48'hFFFF, 1'b1,
			'{ST_REJECTED, 32'd10, 48'h0, 7'd5}},
		'{1'b1, REG_CAPACITY, 7'd127, OP_ENQUEUE, 32'h0, 48'h0, 1'b0, NO_CHECK},
		'{1'b0, REG_POLICY, 7'd0, OP_DEQUEUE, 32'h0, 48'h0, 1'b0, NO_CHECK},
		'{1'b0, REG_POLICY, 7'd0, OP_DEQUEUE, 32'h0, 48'h0, 1'b0, NO_CHECK},
		'{1'b0, REG_POLICY, 7'd0, OP_DEQUEUE, 32'h0, 48'h0, 1'b0, NO_CHECK},
		'{1'b0, REG_POLICY, 7'd0, OP_DEQUEUE, 32'h0, 48'h0, 1'b0, NO_CHECK},
		'{1'b0, REG_POLICY, 7'd0, OP_DEQUEUE, 32'h0, 48'h0, 1'b0, NO_CHECK},
		'{1'b0, REG_POLICY, 7'd0, OP_DEQUEUE, 32'h0, 48'h0, 1'b1,
			'{ST_EMPTY, 32'h0, 48'h0, 7'd0}},
		'{1'b1, REG_CAPACITY, 7'd64, OP_ENQUEUE, 32'h0, 48'h0, 1'b0, NO_CHECK}
	};

	// Register settings of the phases; those of phases 8 to 10 are drawn at random.
	logic             phase_policy [PHASES] = '{
		POLICY_SJN, POLICY_FIFO, POLICY_SJN, POLICY_FIFO, POLICY_SJN, POLICY_SJN,
		POLICY_FIFO, POLICY_SJN, POLICY_SJN, POLICY_SJN, POLICY_SJN, POLICY_SJN
	};
	logic [CAP_W-1:0] phase_cap [PHASES] = '{
		7'd64, 7'd64, 7'd1, 7'd127, 7'd0, 7'd65, 7'd3, 7'd2, 7'd0, 7'd0, 7'd0, 7'd64
	};
	int               phase_items [PHASES] = '{
		200, 200, 100, 200, 40, 200, 120, 120, 150, 150, 150, 200
	};

	// Scoreboard copy of the queue: slot 0 is the head.
	logic [ID_W-1:0]  slot_id  [DEPTH];
	logic [LEN_W-1:0] slot_len [DEPTH];
	int               held_jobs;
	logic             sjn_mode;
	logic [CAP_W-1:0] cap_limit;

	job_result_t pending_results [$];

	int error_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int n_requests     = 0;
	int n_accepted     = 0;
	int n_rejected     = 0;
	int n_dequeued     = 0;
	int n_empty        = 0;
	int n_settings     = 0;
	int peak_held      = 0;

	always begin
		#CLK_HALF_NS clk = 1'b1;
		#CLK_HALF_NS clk = 1'b0;
	end

	// Applies one request to the scoreboard queue and returns its result.
	function automatic job_result_t schedule_job(input logic op, input logic [ID_W-1:0] id,
		input logic [LEN_W-1:0] len);
		job_result_t r;
		int          room;
		int          pos;
		r = '0;
		room = (int'(cap_limit) > DEPTH) ? DEPTH : int'(cap_limit);
		if (op == OP_ENQUEUE) begin
			if (held_jobs >= room) begin
				r.status = ST_REJECTED;
				r.id = id;
				n_rejected++;
			end else begin
				// Shortest-job-next goes before the first strictly longer job.
				pos = held_jobs;
				if (sjn_mode == POLICY_SJN) begin
					for (int k = 0; k < held_jobs; k++) begin
						if (len < slot_len[k]) begin
							pos = k;
							break;
						end
					end
				end
				for (int k = held_jobs; k > pos; k--) begin
					slot_id[k] = slot_id[k-1];
					slot_len[k] = slot_len[k-1];
				end
				slot_id[pos] = id;
				slot_len[pos] = len;
				held_jobs++;
				r.status = ST_ACCEPTED;
				n_accepted++;
				if (held_jobs > peak_held)
					peak_held = held_jobs;
			end
		end else if (held_jobs == 0) begin
			r.status = ST_EMPTY;
			n_empty++;
		end else begin
			r.status = ST_DEQUEUED;
			r.id = slot_id[0];
			r.len = slot_len[0];
			for (int k = 1; k < held_jobs; k++) begin
				slot_id[k-1] = slot_id[k];
				slot_len[k-1] = slot_len[k];
			end
			held_jobs--;
			n_dequeued++;
		end
		r.occ = OCC_W'(held_jobs);
		return r;
	endfunction

	// Lengths favor small values so that ties and reordering happen often.
	function automatic logic [LEN_W-1:0] pick_length();
		logic [LEN_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = LEN_W'($urandom_range(0, 7));
			1: v = '0;
			2: v = LEN_MAX;
			3: v = LEN_W'({$urandom, $urandom});
			4: v = LEN_W'(1) << $urandom_range(0, LEN_W - 1);
			default: v = LEN_W'($urandom_range(0, 1000));
		endcase
		return v;
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		logic [ID_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = ID_MAX;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Offers one request and records its expected result once accepted.
	task automatic offer_request(input logic op, input logic [ID_W-1:0] id,
		input logic [LEN_W-1:0] len, input logic typed, input job_result_t want);
		job_result_t predicted;
		job_ch.valid      <= 1'b1;
		job_ch.opcode     <= op;
		job_ch.job_id     <= id;
		job_ch.job_length <= len;
		@(posedge clk);
		while (!job_ch.ready)
			@(posedge clk);
		predicted = schedule_job(op, id, len);
		pending_results.push_back(typed ? want : predicted);
		n_requests++;
	endtask

	// Random gap between requests, taken with a chance of send_idle_pct percent.
	task automatic sender_gap();
		int n;
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			n = $urandom_range(1, 19);
			job_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stops offering until every outstanding result has come back.
	task automatic drain_results();
		job_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_POLICY)
			sjn_mode = val[0];
		else
			cap_limit = val;
		@(posedge clk);
	endtask

	// Result side: checks each transaction and drives ready with random stalls.
	initial begin : result_sink
		int          stall_left;
		int          hold_left;
		int          seen;
		job_result_t want;
		stall_left = 0;
		hold_left = 0;
		seen = 0;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				seen++;
				if (pending_results.size() == 0) begin
					$error("unexpected result: status %0d id %h length %h occupancy %0d",
						res_ch.status, res_ch.out_job_id, res_ch.out_job_length,
						res_ch.occupancy);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (res_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res_ch.status);
						error_count++;
					end
					if (res_ch.out_job_id !== want.id) begin
						$error("out_job_id: expected %h, got %h", want.id, res_ch.out_job_id);
						error_count++;
					end
					if (res_ch.out_job_length !== want.len) begin
						$error("out_job_length: expected %h, got %h", want.len,
							res_ch.out_job_length);
						error_count++;
					end
					if (res_ch.occupancy !== want.occ) begin
						$error("occupancy: expected %0d, got %0d", want.occ,
							res_ch.occupancy);
						error_count++;
					end
				end
				// Twice in the run, hold off long enough to back up the request side.
				if (seen == 500 || seen == 1300)
					hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
				stall_left = $urandom_range(1, 19) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Request side: reset, directed sequence, then random phases.
	initial begin : stimulus
		logic             mode;
		logic             filling;
		logic             op;
		logic [CAP_W-1:0] cap;
		logic             random_phase;
		int               room;
		job_ch.valid      <= 1'b0;
		job_ch.opcode     <= OP_ENQUEUE;
		job_ch.job_id     <= '0;
		job_ch.job_length <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= REG_POLICY;
		cfg_ch.data       <= '0;
		held_jobs = 0;
		sjn_mode = POLICY_RESET;
		cap_limit = CAPACITY_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 25;
		recv_stall_pct = 25;
		foreach (directed_steps[i]) begin
			if (directed_steps[i].is_cfg) begin
				drain_results();
				write_register(directed_steps[i].reg_idx, directed_steps[i].reg_val);
			end else begin
				sender_gap();
				offer_request(directed_steps[i].op, directed_steps[i].id,
					directed_steps[i].len, directed_steps[i].typed, directed_steps[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			// Registers change only once every result is back; jobs may stay held.
			drain_results();
			random_phase = (ph >= FIRST_RANDOM_PHASE && ph <= LAST_RANDOM_PHASE);
			if (random_phase) begin
				mode = 1'($urandom_range(0, 1));
				cap = CAP_W'($urandom_range(0, 127));
				write_register(REG_POLICY, {(CFG_DATA_W - 1)'($urandom), mode});
			end else begin
				mode = phase_policy[ph];
				cap = phase_cap[ph];
				write_register(REG_POLICY, {{(CFG_DATA_W - 1){1'b0}}, mode});
			end
			write_register(REG_CAPACITY, cap);
			n_settings++;

			// The last phase runs with no idling on either side.
			if (ph == PHASES - 1 || ph % 4 == 1)
				send_idle_pct = 0;
			else
				send_idle_pct = $urandom_range(10, 40);
			if (ph == PHASES - 1 || ph % 4 == 2)
				recv_stall_pct = 0;
			else
				recv_stall_pct = $urandom_range(10, 40);

			// Alternate between filling to capacity and draining to empty.
			filling = 1'b1;
			for (int n = 0; n < phase_items[ph]; n++) begin
				if (ph == PAUSE_PHASE && n == phase_items[ph] / 2)
					drain_results();
				room = (int'(cap_limit) > DEPTH) ? DEPTH : int'(cap_limit);
				if (filling && held_jobs >= room && $urandom_range(0, 99) < 30)
					filling = 1'b0;
				else if (!filling && held_jobs == 0 && $urandom_range(0, 99) < 30)
					filling = 1'b1;
				if ($urandom_range(0, 99) < 80)
					op = filling ? OP_ENQUEUE : OP_DEQUEUE;
				else
					op = filling ? OP_DEQUEUE : OP_ENQUEUE;
				sender_gap();
				offer_request(op, pick_id(), pick_length(), 1'b0, NO_CHECK);
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d requests: %0d accepted, %0d rejected full, %0d dequeued, %0d empty.",
			n_requests, n_accepted, n_rejected, n_dequeued, n_empty);
		$display("Both orderings over %0d register settings, capacity 0 to 127, peak occupancy %0d.",
			n_settings + 1, peak_held);
		if (error_count == 0)
			$display("bounded_shortest_job_queue_test: done, clean");
		else
			$display("bounded_shortest_job_queue_test: done, errors");
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_NS);
		$display("bounded_shortest_job_queue_test: done, errors");
		$finish;
	end

endmodule
